[rtl/lj_pkg.sv]
// shared types and constants for the lennard-jones pair energy unit
package lj_pkg;

  localparam int SPECIES = 4;
  localparam int SP_W = 2;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DIST_W = 32;
  localparam int EPS_W = 32;
  localparam int S2_W = 34;
  localparam int FRAC_SHIFT = 24;
  localparam int QUO_W = S2_W + FRAC_SHIFT;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W = 6;
  localparam int E_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_EPS_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIGMA_BASE = 3'd4;

  localparam logic [E_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [E_W-1:0] NEG_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [SP_W-1:0]   atom_species;
    logic [SP_W-1:0]   neighbour_species;
    logic              neighbour_active;
    logic              is_self;
    logic              use_new;
    logic              use_old;
    logic [DIST_W-1:0] new_dist_sq;
    logic [DIST_W-1:0] old_dist_sq;
    logic              last_neighbour;
  } in_t;

  typedef struct packed {
    logic signed [E_W-1:0] energy_new_sum;
    logic signed [E_W-1:0] energy_old_sum;
    logic                  saturated;
  } out_t;

  typedef struct packed {
    logic [EPS_W-1:0]  eps;
    logic [S2_W-1:0]   s2;
    logic [DIST_W-1:0] r2_new;
    logic [DIST_W-1:0] r2_old;
    logic              do_new;
    logic              do_old;
    logic              last;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SIDE,
    BK_DIV,
    BK_MUL,
    BK_MEND,
    BK_ACC,
    BK_DONE
  } bk_state_e;

  typedef enum logic [1:0] {
    MOP_X2,
    MOP_X3,
    MOP_X6,
    MOP_TERM
  } mul_op_e;

endpackage

[rtl/lennard_jones_pair_energy_sum_unit.sv]
// top level of the lennard-jones 12-6 pair energy accumulator
// a counted pair runs the 58-step serial divider and the four-pass 32x32 multiplier
// for each position it uses, a zero distance side skips both, an uncounted pair skips
// all of that work, and one pair is worked at a time; the front end takes a transaction
// per cycle while the two-entry queue has room; reset clears parameters, sums, flag,
// queue, out valid
module lennard_jones_pair_energy_sum_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lj_pkg::in_t                  in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lj_pkg::out_t                 out_data_o,
  input  logic                         cfg_we_i,
  input  logic [lj_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lj_pkg::CFG_W-1:0]     cfg_data_i
);
  import lj_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, pop_job;

  lj_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  lj_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  lj_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/lj_front.sv]
// front end: parameter registers, pair classification, epsilon and sigma squared
module lj_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lj_pkg::in_t                  in_data_i,
  input  logic                         cfg_we_i,
  input  logic [lj_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lj_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                         full_i,
  output logic                         push_o,
  output lj_pkg::job_t                 job_o
);
  import lj_pkg::*;

  logic [CFG_W-1:0] root_eps_q [SPECIES];
  logic [CFG_W-1:0] half_sigma_q [SPECIES];
  logic [CFG_W-1:0] re_a, re_n, hs_a, hs_n;
  logic [CFG_W:0]   sigma;
  logic             counted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SPECIES; i++) begin
        root_eps_q[i] <= '0;
        half_sigma_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < CFG_HALF_SIGMA_BASE) begin
        root_eps_q[SP_W'(cfg_idx_i - CFG_ROOT_EPS_BASE)] <= cfg_data_i;
      end else begin
        half_sigma_q[SP_W'(cfg_idx_i - CFG_HALF_SIGMA_BASE)] <= cfg_data_i;
      end
    end
  end

  always_comb begin
    re_a = root_eps_q[in_data_i.atom_species];
    re_n = root_eps_q[in_data_i.neighbour_species];
    hs_a = half_sigma_q[in_data_i.atom_species];
    hs_n = half_sigma_q[in_data_i.neighbour_species];
    sigma = {1'b0, hs_a} + {1'b0, hs_n};
    counted = in_data_i.neighbour_active && !in_data_i.is_self
              && ({1'b0, in_data_i.atom_species} < (SP_W+1)'(SPECIES))
              && ({1'b0, in_data_i.neighbour_species} < (SP_W+1)'(SPECIES));
    job_o.eps = re_a * re_n;
    job_o.s2 = S2_W'(sigma) * S2_W'(sigma);
    job_o.r2_new = in_data_i.new_dist_sq;
    job_o.r2_old = in_data_i.old_dist_sq;
    job_o.do_new = counted && in_data_i.use_new;
    job_o.do_old = counted && in_data_i.use_old;
    job_o.last = in_data_i.last_neighbour;
  end

  assign in_ready_o = !full_i;
  assign push_o = in_valid_i && !full_i;

endmodule

[rtl/lj_fifo.sv]
// two-entry job queue between front and back end
module lj_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lj_pkg::job_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output lj_pkg::job_t pop_data_o,
  output logic         empty_o
);
  import lj_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

[rtl/lj_back.sv]
// back end: serial divide, shared 32x32 multiplier, saturating accumulators
module lj_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  lj_pkg::job_t job_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output lj_pkg::out_t out_data_o
);
  import lj_pkg::*;

  bk_state_e           state_q, state_d;
  job_t                job_q;
  logic                side_q;
  logic [DIST_W-1:0]   rem_q;
  logic [QUO_W-1:0]    quo_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [E_W-1:0]      x_q, x3_q, ma_q, mb_q, term_q;
  logic [2*E_W-1:0]    prod_q;
  logic [1:0]          k_q;
  mul_op_e             op_q;
  logic                neg_q, tsat_q;
  logic [E_W-1:0]      acc_new_q, acc_old_q;
  logic                sat_seen_q;
  logic                out_valid_q;
  out_t                out_q;

  logic [DIST_W-1:0]   r2;
  logic [DIST_W:0]     rem_sh;
  logic [DIST_W+1:0]   trial;
  logic                ge;
  logic [E_W-1:0]      x_fin;
  logic [31:0]         a_part, b_part;
  logic [63:0]         pp;
  logic [1:0]          shamt;
  logic [2*E_W-1:0]    pp_sh;
  logic [E_W-1:0]      mres, mag, term_fin, cur, sum, acc_res;
  logic                movf, neg, term_sat, aovf;
  logic                pop, load_out;

  always_comb begin
    r2 = side_q ? job_q.r2_old : job_q.r2_new;
    rem_sh = {rem_q, quo_q[QUO_W-1]};
    trial = {1'b0, rem_sh} - {2'b0, r2};
    ge = !trial[DIST_W+1];
    x_fin = E_W'({quo_q[QUO_W-2:0], ge});

    a_part = k_q[0] ? ma_q[63:32] : ma_q[31:0];
    b_part = k_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp = a_part * b_part;
    shamt = {1'b0, k_q[0]} + {1'b0, k_q[1]};
    pp_sh = (2*E_W)'(pp) << {shamt, 5'b0};

    if (op_q == MOP_TERM) begin
      mres = prod_q[87:24];
      movf = |prod_q[127:88];
    end else begin
      mres = prod_q[95:32];
      movf = |prod_q[127:96];
    end
    neg = mres < x3_q;
    mag = neg ? x3_q - mres : mres - x3_q;

    if (!neg_q) begin
      term_sat = movf || mres[E_W-1];
      term_fin = term_sat ? POS_MAX : mres;
    end else begin
      term_sat = movf || (mres > NEG_MIN);
      term_fin = term_sat ? NEG_MIN : (~mres) + 64'd1;
    end

    cur = side_q ? acc_old_q : acc_new_q;
    sum = cur + term_q;
    aovf = (cur[E_W-1] == term_q[E_W-1]) && (sum[E_W-1] != cur[E_W-1]);
    acc_res = aovf ? (cur[E_W-1] ? NEG_MIN : POS_MAX) : sum;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = (job_i.do_new || job_i.do_old) ? BK_SIDE : BK_DONE;
        end
      end
      BK_SIDE: state_d = (r2 == '0) ? BK_ACC : BK_DIV;
      BK_DIV: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        if (k_q == 2'd3) begin
          state_d = BK_MEND;
        end
      end
      BK_MEND: begin
        if (movf || op_q == MOP_TERM) begin
          state_d = BK_ACC;
        end else begin
          state_d = BK_MUL;
        end
      end
      BK_ACC: state_d = (!side_q && job_q.do_old) ? BK_SIDE : BK_DONE;
      BK_DONE: begin
        if (!job_q.last || !out_valid_q || out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: pop = !empty_i;
      BK_DONE: load_out = job_q.last && (!out_valid_q || out_ready_i);
      default: begin
        pop = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      acc_new_q <= '0;
      acc_old_q <= '0;
      sat_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_ACC) begin
        if (side_q) begin
          acc_old_q <= acc_res;
        end else begin
          acc_new_q <= acc_res;
        end
        if (tsat_q || aovf) begin
          sat_seen_q <= 1'b1;
        end
      end
      if (load_out) begin
        acc_new_q <= '0;
        acc_old_q <= '0;
        sat_seen_q <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          job_q <= job_i;
          side_q <= !job_i.do_new;
        end
      end
      BK_SIDE: begin
        rem_q <= '0;
        quo_q <= {job_q.s2, FRAC_SHIFT'(0)};
        cnt_q <= '0;
        tsat_q <= (r2 == '0);
        term_q <= POS_MAX;
      end
      BK_DIV: begin
        rem_q <= ge ? trial[DIST_W-1:0] : rem_sh[DIST_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], ge};
        cnt_q <= cnt_q + CNT_W'(1);
        x_q <= x_fin;
        ma_q <= x_fin;
        mb_q <= x_fin;
        op_q <= MOP_X2;
        k_q <= 2'd0;
        prod_q <= '0;
      end
      BK_MUL: begin
        prod_q <= prod_q + pp_sh;
        k_q <= k_q + 2'd1;
      end
      BK_MEND: begin
        k_q <= 2'd0;
        prod_q <= '0;
        if (movf && op_q != MOP_TERM) begin
          tsat_q <= 1'b1;
          term_q <= POS_MAX;
        end else begin
          case (op_q)
            MOP_X2: begin
              ma_q <= mres;
              mb_q <= x_q;
              op_q <= MOP_X3;
            end
            MOP_X3: begin
              x3_q <= mres;
              ma_q <= mres;
              mb_q <= mres;
              op_q <= MOP_X6;
            end
            MOP_X6: begin
              neg_q <= neg;
              ma_q <= E_W'(job_q.eps);
              mb_q <= mag;
              op_q <= MOP_TERM;
            end
            MOP_TERM: begin
              term_q <= term_fin;
              tsat_q <= term_sat;
            end
            default: op_q <= MOP_X2;
          endcase
        end
      end
      BK_ACC: begin
        side_q <= 1'b1;
      end
      BK_DONE: begin
        if (load_out) begin
          out_q.energy_new_sum <= acc_new_q;
          out_q.energy_old_sum <= acc_old_q;
          out_q.saturated <= sat_seen_q;
        end
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  assign pop_o = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

[dv/tb_top.sv]
// testbench for the lennard-jones pair energy accumulator: directed and random lists vs a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lj_pkg::*;

  localparam int DRAIN_CYCLES = 600;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 700;

  class energy_scoreboard;
    logic [CFG_W-1:0] root_eps[SPECIES];
    logic [CFG_W-1:0] half_sigma[SPECIES];
    logic [E_W-1:0] new_acc, old_acc;
    bit sat_acc;
    out_t sums_q[$];
    int mismatches, sums_seen, sat_sums;

    function new();
      for (int i = 0; i < SPECIES; i++) begin
        root_eps[i] = '0;
        half_sigma[i] = '0;
      end
      new_acc = '0;
      old_acc = '0;
      sat_acc = 0;
    endfunction

    function void set_reg(int idx, logic [CFG_W-1:0] v);
      if (idx < int'(CFG_HALF_SIGMA_BASE)) root_eps[idx] = v;
      else half_sigma[idx - int'(CFG_HALF_SIGMA_BASE)] = v;
    endfunction

    function logic [E_W-1:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh, inout bit ovf);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if ((p >> (64 + sh)) != 0) begin
        ovf = 1;
        return '0;
      end
      return p[63:0] >> sh | (p[127:64] << (64 - sh));
    endfunction

    function logic [E_W-1:0] pair_energy(logic [63:0] eps, logic [63:0] s2,
                                         logic [63:0] r2, inout bit sat);
      logic [63:0] x, x2, x3, x6, mag, t;
      bit ovf, neg;
      ovf = 0;
      if (r2 == 0) begin
        sat = 1;
        return POS_MAX;
      end
      x = (s2 << FRAC_SHIFT) / r2;
      x2 = mul_shift(x, x, 32, ovf);
      x3 = ovf ? '0 : mul_shift(x2, x, 32, ovf);
      x6 = ovf ? '0 : mul_shift(x3, x3, 32, ovf);
      if (ovf) begin
        sat = 1;
        return POS_MAX;
      end
      neg = x6 < x3;
      mag = neg ? x3 - x6 : x6 - x3;
      t = mul_shift(eps, mag, FRAC_SHIFT, ovf);
      if (!neg) begin
        if (ovf || t > POS_MAX) begin
          sat = 1;
          return POS_MAX;
        end
        return t;
      end
      if (ovf || t > NEG_MIN) begin
        sat = 1;
        return NEG_MIN;
      end
      return ~t + 64'd1;
    endfunction

    function logic [E_W-1:0] add_clamped(logic [E_W-1:0] a, logic [E_W-1:0] b, inout bit sat);
      logic [E_W-1:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
        sat = 1;
        return a[63] ? NEG_MIN : POS_MAX;
      end
      return s;
    endfunction

    function void note_pair(in_t it);
      logic [63:0] eps, sig, s2, term;
      bit sat;
      out_t r;
      sat = 0;
      if (it.neighbour_active && !it.is_self) begin
        eps = root_eps[it.atom_species] * root_eps[it.neighbour_species];
        sig = half_sigma[it.atom_species] + half_sigma[it.neighbour_species];
        s2 = sig * sig;
        if (it.use_new) begin
          term = pair_energy(eps, s2, it.new_dist_sq, sat);
          new_acc = add_clamped(new_acc, term, sat);
        end
        if (it.use_old) begin
          term = pair_energy(eps, s2, it.old_dist_sq, sat);
          old_acc = add_clamped(old_acc, term, sat);
        end
        if (sat) sat_acc = 1;
      end
      if (it.last_neighbour) begin
        r.energy_new_sum = new_acc;
        r.energy_old_sum = old_acc;
        r.saturated = sat_acc;
        sums_q.push_back(r);
        new_acc = '0;
        old_acc = '0;
        sat_acc = 0;
      end
    endfunction

    function void check_sum(out_t got);
      out_t exp_r;
      sums_seen++;
      if (sums_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      exp_r = sums_q.pop_front();
      if (exp_r.saturated) sat_sums++;
      if (got.energy_new_sum !== exp_r.energy_new_sum ||
          got.energy_old_sum !== exp_r.energy_old_sum ||
          got.saturated !== exp_r.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sum %0d mismatch: new exp %h got %h, old exp %h got %h, sat exp %b got %b",
                   sums_seen, exp_r.energy_new_sum, got.energy_new_sum,
                   exp_r.energy_old_sum, got.energy_old_sum, exp_r.saturated, got.saturated);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  out_t out_data_o;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  energy_scoreboard sb = new();
  int pairs_sent;
  int idle_cycles;
  bit hold_req;

  lennard_jones_pair_energy_sum_unit dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic write_config(logic [CFG_W-1:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1;
      cfg_idx_i <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      sb.set_reg(i, vals[i]);
    end
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic send_pair(in_t it);
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pair(it);
    pairs_sent++;
  endtask

  task automatic pause_sender(int n);
    in_valid_i <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (sb.sums_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [DIST_W-1:0] pick_dist(logic [1:0] a, logic [1:0] n);
    logic [63:0] sig, base;
    int sel;
    sig = sb.half_sigma[a] + sb.half_sigma[n];
    base = (sig * sig) >> 8;
    sel = $urandom_range(0, 99);
    if (sel < 3) return '0;
    if (sel < 15 || base == 0 || base > 64'h3FFF_FFFF) return $urandom;
    if (sel < 22) return $urandom_range(1, 255);
    return DIST_W'(base * $urandom_range(70, 400) / 100);
  endfunction

  function automatic in_t rand_pair(logic [1:0] a, bit last);
    in_t it;
    it.atom_species = a;
    it.neighbour_species = 2'($urandom_range(0, 3));
    it.neighbour_active = $urandom_range(0, 9) != 0;
    it.is_self = $urandom_range(0, 11) == 0;
    it.use_new = $urandom_range(0, 4) != 0;
    it.use_old = $urandom_range(0, 4) != 0;
    it.new_dist_sq = pick_dist(a, it.neighbour_species);
    it.old_dist_sq = pick_dist(a, it.neighbour_species);
    it.last_neighbour = last;
    return it;
  endfunction

  function automatic in_t mk(logic [1:0] a, logic [1:0] n, bit act, bit slf, bit un, bit uo,
                             logic [31:0] rn, logic [31:0] ro, bit last);
    in_t it;
    it = '{a, n, act, slf, un, uo, rn, ro, last};
    return it;
  endfunction

  task automatic directed_pairs();
    send_pair(mk(0, 0, 1, 0, 1, 1, 32'h0004_0000, 32'h0008_0000, 0));
    send_pair(mk(1, 2, 1, 0, 1, 0, 32'h0000_0000, 32'h0004_0000, 1));
    send_pair(mk(2, 3, 1, 0, 0, 1, 32'h0002_0000, 32'h0000_0000, 1));
    send_pair(mk(3, 3, 0, 0, 1, 1, 32'h0000_0000, 32'h0000_0000, 0));
    send_pair(mk(3, 1, 1, 1, 1, 1, 32'h0000_0000, 32'h0001_0000, 1));
    send_pair(mk(0, 1, 1, 0, 0, 0, 32'h0000_0000, 32'h0000_0000, 1));
    send_pair(mk(1, 1, 1, 0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    send_pair(mk(2, 2, 1, 0, 1, 1, 32'h0000_0001, 32'h0000_0002, 1));
    send_pair(mk(0, 3, 1, 0, 1, 1, 32'h0000_0000, 32'h0000_0000, 0));
    send_pair(mk(3, 0, 1, 0, 1, 1, 32'h0000_0000, 32'h0000_0000, 1));
    send_pair(mk(1, 3, 1, 0, 1, 1, 32'h0010_0000, 32'h0006_0000, 0));
    send_pair(mk(2, 0, 1, 0, 1, 1, 32'h0003_8000, 32'h0020_0000, 0));
    send_pair(mk(3, 2, 1, 0, 1, 1, 32'h5555_AAAA, 32'hAAAA_5555, 1));
    send_pair(mk(0, 2, 1, 0, 1, 0, 32'h0000_0100, 32'h0000_0000, 1));
    send_pair(mk(1, 0, 1, 0, 0, 0, 32'h0000_0000, 32'h0000_0000, 0));
    send_pair(mk(2, 1, 1, 0, 1, 1, 32'h0005_0000, 32'h0003_0000, 1));
  endtask

  task automatic random_lists(int n_pairs);
    int burst, list_len;
    logic [1:0] a;
    burst = 0;
    list_len = 0;
    a = 0;
    for (int k = 0; k < n_pairs; k++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        burst = $urandom_range(1, 20);
      end
      burst--;
      if (list_len == 0) begin
        list_len = $urandom_range(1, 10);
        a = 2'($urandom_range(0, 3));
      end
      list_len--;
      if ($urandom_range(0, 9) == 0)
        send_pair(rand_pair(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
      else send_pair(rand_pair(a, list_len == 0 || k == n_pairs - 1));
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_sum(out_data_o);
  end

  initial begin
    int mode;
    mode = 0;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready_i <= 1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= $urandom_range(0, 4) == 0;
      endcase
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress, %0d sums pending", sb.sums_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] vals[8];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 8; i++) begin
        case (ph)
          1: vals[i] = 16'hFFFF;
          2: vals[i] = (i < 4) ? 16'h0000 : 16'(16'h0800 + $urandom_range(0, 16'h1000));
          3: vals[i] = 16'($urandom);
          default: vals[i] = (i < 4) ? 16'($urandom_range(16'h0400, 16'h2000))
                                     : 16'($urandom_range(16'h0600, 16'h1800));
        endcase
      end
      write_config(vals);
      if (ph == 0) directed_pairs();
      if (ph == 4) hold_req = 1;
      random_lists(ph == 0 ? 135 : 150);
      wait_idle();
    end
    $display("%0d pairs sent over 5 register settings, %0d sums checked, %0d saturated",
             pairs_sent, sb.sums_seen, sb.sat_sums);
    if (sb.mismatches == 0 && sb.sums_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[lennard_jones_pair_energy_sum_unit.f]
rtl/lj_pkg.sv
rtl/lj_front.sv
rtl/lj_fifo.sv
rtl/lj_back.sv
rtl/lennard_jones_pair_energy_sum_unit.sv
dv/tb_top.sv
